### hdl/krt_pkg.sv
`default_nettype none

package krt_pkg;

  // field widths fixed by the interface
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned QTY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 7;

  localparam int unsigned DEFAULT_ENTRIES = 128;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                       valid;
    logic [STATUS_W-1:0]        status;
    logic signed [QTY_W-1:0]    qty;
    logic [SLOT_W-1:0]          slot;
  } res_t;

endpackage

`default_nettype wire

### hdl/krt_mem.sv
`default_nettype none

module krt_mem #(
  parameter int unsigned ENTRIES = krt_pkg::DEFAULT_ENTRIES,
  parameter int unsigned IW      = $clog2(ENTRIES)
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [IW-1:0]                     waddr,
  input  wire logic [krt_pkg::KEY_W-1:0]         wkey,
  input  wire logic signed [krt_pkg::QTY_W-1:0]  wqty,
  input  wire logic                              re,
  input  wire logic [IW-1:0]                     raddr,
  output logic [krt_pkg::KEY_W-1:0]              rkey,
  output logic signed [krt_pkg::QTY_W-1:0]       rqty
);

  logic [krt_pkg::KEY_W-1:0]        key_mem [ENTRIES];
  logic signed [krt_pkg::QTY_W-1:0] qty_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      qty_mem[waddr] <= wqty;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rkey <= key_mem[raddr];
      rqty <= qty_mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/krt_seq.sv
`default_nettype none

module krt_seq #(
  parameter int unsigned ENTRIES = krt_pkg::DEFAULT_ENTRIES,
  parameter int unsigned IW      = $clog2(ENTRIES),
  parameter int unsigned CW      = $clog2(ENTRIES + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   busy,
  input  wire logic [krt_pkg::OP_W-1:0]          operation,
  input  wire logic [krt_pkg::KEY_W-1:0]         part_key,
  input  wire logic signed [krt_pkg::QTY_W-1:0]  quantity_value,
  output logic                                   we,
  output logic [IW-1:0]                          waddr,
  output logic [krt_pkg::KEY_W-1:0]              wkey,
  output logic signed [krt_pkg::QTY_W-1:0]       wqty,
  output logic                                   re,
  output logic [IW-1:0]                          raddr,
  input  wire logic [krt_pkg::KEY_W-1:0]         rkey,
  input  wire logic signed [krt_pkg::QTY_W-1:0]  rqty,
  output krt_pkg::res_t                          res,
  input  wire logic                              res_take
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  logic [1:0]                        state, state_next;
  logic [krt_pkg::OP_W-1:0]          op, op_next;
  logic [krt_pkg::KEY_W-1:0]         key, key_next;
  logic signed [krt_pkg::QTY_W-1:0]  val, val_next;
  logic [IW-1:0]                     cmp_idx, cmp_idx_next;
  logic [CW-1:0]                     count, count_next;
  logic [krt_pkg::STATUS_W-1:0]      res_status, res_status_next;
  logic signed [krt_pkg::QTY_W-1:0]  res_qty, res_qty_next;
  logic [krt_pkg::SLOT_W-1:0]        res_slot, res_slot_next;

  logic                              hit;
  logic                              last;
  logic signed [krt_pkg::QTY_W:0]    sum;
  logic signed [krt_pkg::QTY_W-1:0]  sat;

  assign hit  = (rkey == key);
  assign last = ((CW'(cmp_idx) + CW'(1)) == count);

  // shared adder with saturation at the 32-bit signed limits
  always_comb begin
    sum = {rqty[krt_pkg::QTY_W-1], rqty} + {val[krt_pkg::QTY_W-1], val};
    if (sum[krt_pkg::QTY_W] != sum[krt_pkg::QTY_W-1]) begin
      sat = sum[krt_pkg::QTY_W] ? {1'b1, {(krt_pkg::QTY_W-1){1'b0}}}
                                : {1'b0, {(krt_pkg::QTY_W-1){1'b1}}};
    end else begin
      sat = sum[krt_pkg::QTY_W-1:0];
    end
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    val_next        = val;
    cmp_idx_next    = cmp_idx;
    count_next      = count;
    res_status_next = res_status;
    res_qty_next    = res_qty;
    res_slot_next   = res_slot;
    we              = 1'b0;
    waddr           = IW'(count);
    wkey            = key;
    wqty            = val;
    re              = 1'b0;
    raddr           = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next  = operation;
          key_next = part_key;
          val_next = quantity_value;
          res_qty_next  = '0;
          res_slot_next = '0;
          if (operation == krt_pkg::OP_INSERT && count == FULL_COUNT) begin
            res_status_next = krt_pkg::ST_FULL;
            state_next      = S_HOLD;
          end else if ((operation == krt_pkg::OP_INSERT ||
                        operation == krt_pkg::OP_SEARCH ||
                        operation == krt_pkg::OP_UPDATE) && count != '0) begin
            re           = 1'b1;
            raddr        = '0;
            cmp_idx_next = '0;
            state_next   = S_SCAN;
          end else if (operation == krt_pkg::OP_INSERT) begin
            // empty table, insert straight at entry zero
            we              = 1'b1;
            wkey            = part_key;
            wqty            = quantity_value;
            res_status_next = krt_pkg::ST_OK;
            res_qty_next    = quantity_value;
            res_slot_next   = krt_pkg::SLOT_W'(count);
            count_next      = count + CW'(1);
            state_next      = S_HOLD;
          end else begin
            res_status_next = krt_pkg::ST_MISS;
            state_next      = S_HOLD;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          case (op)
            krt_pkg::OP_INSERT: begin
              res_status_next = krt_pkg::ST_DUP;
              state_next      = S_HOLD;
            end
            krt_pkg::OP_SEARCH: begin
              res_status_next = krt_pkg::ST_OK;
              res_qty_next    = rqty;
              res_slot_next   = krt_pkg::SLOT_W'(cmp_idx);
              state_next      = S_HOLD;
            end
            krt_pkg::OP_UPDATE: begin
              state_next = S_UPD;
            end
            default: begin
              res_status_next = krt_pkg::ST_MISS;
              state_next      = S_HOLD;
            end
          endcase
        end else if (last) begin
          if (op == krt_pkg::OP_INSERT) begin
            we              = 1'b1;
            res_status_next = krt_pkg::ST_OK;
            res_qty_next    = val;
            res_slot_next   = krt_pkg::SLOT_W'(count);
            count_next      = count + CW'(1);
          end else begin
            res_status_next = krt_pkg::ST_MISS;
          end
          state_next = S_HOLD;
        end else begin
          re           = 1'b1;
          raddr        = cmp_idx + IW'(1);
          cmp_idx_next = cmp_idx + IW'(1);
        end
      end

      S_UPD: begin
        // read data still holds the matched entry
        we              = 1'b1;
        waddr           = cmp_idx;
        wkey            = rkey;
        wqty            = sat;
        res_status_next = krt_pkg::ST_OK;
        res_qty_next    = sat;
        res_slot_next   = krt_pkg::SLOT_W'(cmp_idx);
        state_next      = S_HOLD;
      end

      S_HOLD: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    key        <= key_next;
    val        <= val_next;
    cmp_idx    <= cmp_idx_next;
    res_status <= res_status_next;
    res_qty    <= res_qty_next;
    res_slot   <= res_slot_next;
  end

  assign busy       = (state != S_IDLE);
  assign res.valid  = (state == S_HOLD);
  assign res.status = res_status;
  assign res.qty    = res_qty;
  assign res.slot   = res_slot;

endmodule

`default_nettype wire

### hdl/keyed_record_table_core.sv
`default_nettype none

// channel   dir  handshake          payload
// input     in   in_valid/in_stall  operation, part_key, quantity_value
// output    out  out_valid/out_stall status, quantity_out, slot_index
//
// a word needs no lookup for an insert into a full table, an empty table or an
// unused code; otherwise the key scan stops at a hit or after the last record,
// and an update adds a write-back; the key scan reads one entry per cycle from the single read port
// reset (rst, synchronous) empties the table and drops any pending result;
// record contents are not cleared, only the fill count
// out_stall holds the finished word in the output register; one more word is
// worked on meanwhile and waits in the sequencer until the register frees up

module keyed_record_table_core #(
  parameter int unsigned ENTRIES = krt_pkg::DEFAULT_ENTRIES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [krt_pkg::OP_W-1:0]             operation,
  input  wire logic [krt_pkg::KEY_W-1:0]            part_key,
  input  wire logic signed [krt_pkg::QTY_W-1:0]     quantity_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [krt_pkg::STATUS_W-1:0]              status,
  output logic signed [krt_pkg::QTY_W-1:0]          quantity_out,
  output logic [krt_pkg::SLOT_W-1:0]                slot_index
);

  // entry index and fill count widths
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // memory port wires
  logic                              we;
  logic [IW-1:0]                     waddr;
  logic [krt_pkg::KEY_W-1:0]         wkey;
  logic signed [krt_pkg::QTY_W-1:0]  wqty;
  logic                              re;
  logic [IW-1:0]                     raddr;
  logic [krt_pkg::KEY_W-1:0]         rkey;
  logic signed [krt_pkg::QTY_W-1:0]  rqty;

  krt_pkg::res_t res;
  logic          busy;
  logic          out_free;

  // record storage, one write and one registered read per cycle
  krt_mem #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wkey  (wkey),
    .wqty  (wqty),
    .re    (re),
    .raddr (raddr),
    .rkey  (rkey),
    .rqty  (rqty)
  );

  // scan sequencer with the key compare and the saturating adder
  krt_seq #(
    .ENTRIES (ENTRIES),
    .IW      (IW),
    .CW      (CW)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .busy           (busy),
    .operation      (operation),
    .part_key       (part_key),
    .quantity_value (quantity_value),
    .we             (we),
    .waddr          (waddr),
    .wkey           (wkey),
    .wqty           (wqty),
    .re             (re),
    .raddr          (raddr),
    .rkey           (rkey),
    .rqty           (rqty),
    .res            (res),
    .res_take       (out_free)
  );

  // new words are taken only while the sequencer is idle
  assign in_stall = busy;

  // output register empties or is being drained this cycle
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  // payload loads only when a result moves across
  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      status       <= res.status;
      quantity_out <= res.qty;
      slot_index   <= res.slot;
    end
  end

endmodule

`default_nettype wire
